[rtl/tlvp_pkg.sv]
// ----------------------------------------------------------------------------
// tlvp_pkg
// Shared types and codes for the type-length-value frame parser.
// ----------------------------------------------------------------------------
package tlvp_pkg;

  localparam int HEADER_BYTES = 13;

  // Parser phase codes.
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_FHDR   = 3'd1;
  localparam logic [2:0] PH_VALUE  = 3'd2;
  localparam logic [2:0] PH_DONE   = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;

  // Event codes.
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_HEADER = 2'd1;
  localparam logic [1:0] EV_FHDR   = 2'd2;
  localparam logic [1:0] EV_VALUE  = 2'd3;

  // Frame status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
  localparam logic [2:0] ST_TRUNC_HDR = 3'd3;
  localparam logic [2:0] ST_TRUNC_VAL = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_last;
  } item_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  opcode;
    logic [7:0]  flag_bits;
    logic [7:0]  field_count;
    logic [31:0] sequence_res;
    logic [31:0] payload_length;
    logic [7:0]  field_ident;
    logic [15:0] field_length;
    logic [7:0]  value_byte;
    logic [15:0] value_index;
    logic        frame_end;
    logic [2:0]  status;
  } result_t;

endpackage

[rtl/tlvp_parse.sv]
// ----------------------------------------------------------------------------
// tlvp_parse
// Parser state and the per-byte update. Produces one result per byte.
// ----------------------------------------------------------------------------
module tlvp_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  tlvp_pkg::item_t  item,
  input  logic [15:0]      magic_word,
  output tlvp_pkg::result_t result
);
  import tlvp_pkg::*;

  logic [2:0]  phase, phase_next;
  logic [3:0]  header_position, header_position_next;
  logic [7:0]  first_magic_byte, first_magic_byte_next;
  logic        magic_bad, magic_bad_next;
  logic [7:0]  opcode_reg, opcode_reg_next;
  logic [7:0]  flags_reg, flags_reg_next;
  logic [7:0]  fields_total, fields_total_next;
  logic [7:0]  fields_left, fields_left_next;
  logic [31:0] sequence_reg, sequence_reg_next;
  logic [31:0] payload_length_reg, payload_length_reg_next;
  logic [1:0]  field_header_position, field_header_position_next;
  logic [7:0]  current_ident, current_ident_next;
  logic [15:0] current_length, current_length_next;
  logic [15:0] value_position, value_position_next;

  logic [1:0]  ev;
  logic [7:0]  vb;
  logic [15:0] vi;
  logic [2:0]  st;
  logic [7:0]  b;

  assign b = item.data_byte;

  always_comb begin
    phase_next                 = phase;
    header_position_next       = header_position;
    first_magic_byte_next      = first_magic_byte;
    magic_bad_next             = magic_bad;
    opcode_reg_next            = opcode_reg;
    flags_reg_next             = flags_reg;
    fields_total_next          = fields_total;
    fields_left_next           = fields_left;
    sequence_reg_next          = sequence_reg;
    payload_length_reg_next    = payload_length_reg;
    field_header_position_next = field_header_position;
    current_ident_next         = current_ident;
    current_length_next        = current_length;
    value_position_next        = value_position;
    ev = EV_NONE;
    vb = 8'd0;
    vi = 16'd0;
    st = ST_OK;

    unique case (phase)
      PH_HEADER: begin
        unique case (header_position)
          4'd0: first_magic_byte_next = b;
          4'd1: magic_bad_next = ({first_magic_byte, b} != magic_word);
          4'd2: opcode_reg_next = b;
          4'd3: flags_reg_next = b;
          4'd4: fields_total_next = b;
          4'd5, 4'd6, 4'd7, 4'd8: sequence_reg_next = {sequence_reg[23:0], b};
          default: payload_length_reg_next = {payload_length_reg[23:0], b};
        endcase
        if (header_position >= 4'(HEADER_BYTES - 1)) begin
          header_position_next = 4'd0;
          if (magic_bad) begin
            phase_next = PH_SKIP;
          end else begin
            ev                         = EV_HEADER;
            fields_left_next           = fields_total;
            field_header_position_next = 2'd0;
            value_position_next        = 16'd0;
            phase_next = (fields_total != 8'd0) ? PH_FHDR : PH_DONE;
          end
        end else begin
          header_position_next = header_position + 4'd1;
        end
      end
      PH_FHDR: begin
        unique case (field_header_position)
          2'd0: begin
            current_ident_next         = b;
            field_header_position_next = 2'd1;
          end
          2'd1: begin
            current_length_next        = {b, 8'h00};
            field_header_position_next = 2'd2;
          end
          default: begin
            current_length_next        = current_length | {8'h00, b};
            field_header_position_next = 2'd0;
            value_position_next        = 16'd0;
            ev                         = EV_FHDR;
            if (current_length_next == 16'd0) begin
              // An empty field closes with its header.
              fields_left_next = fields_left - 8'd1;
              phase_next = (fields_left_next != 8'd0) ? PH_FHDR : PH_DONE;
            end else begin
              phase_next = PH_VALUE;
            end
          end
        endcase
      end
      PH_VALUE: begin
        ev = EV_VALUE;
        vb = b;
        vi = value_position;
        value_position_next = value_position + 16'd1;
        if (value_position_next == current_length) begin
          fields_left_next           = fields_left - 8'd1;
          field_header_position_next = 2'd0;
          value_position_next        = 16'd0;
          phase_next = (fields_left_next != 8'd0) ? PH_FHDR : PH_DONE;
        end
      end
      default: begin
        // Done, skipping after a bad magic word, or an unused code: ignore.
      end
    endcase

    if (item.frame_last) begin
      unique case (phase_next)
        PH_HEADER: st = ST_TOO_SHORT;
        PH_SKIP:   st = ST_BAD_MAGIC;
        PH_FHDR:   st = ST_TRUNC_HDR;
        PH_VALUE:  st = ST_TRUNC_VAL;
        default:   st = ST_OK;
      endcase
      phase_next                 = PH_HEADER;
      header_position_next       = 4'd0;
      magic_bad_next             = 1'b0;
      field_header_position_next = 2'd0;
      value_position_next        = 16'd0;
    end
  end

  always_comb begin
    result.event_res      = ev;
    result.opcode         = opcode_reg_next;
    result.flag_bits      = flags_reg_next;
    result.field_count    = fields_total_next;
    result.sequence_res   = sequence_reg_next;
    result.payload_length = payload_length_reg_next;
    result.field_ident    = current_ident_next;
    result.field_length   = current_length_next;
    result.value_byte     = vb;
    result.value_index    = vi;
    result.frame_end      = item.frame_last;
    result.status         = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                 <= PH_HEADER;
      header_position       <= 4'd0;
      first_magic_byte      <= 8'd0;
      magic_bad             <= 1'b0;
      opcode_reg            <= 8'd0;
      flags_reg             <= 8'd0;
      fields_total          <= 8'd0;
      fields_left           <= 8'd0;
      sequence_reg          <= 32'd0;
      payload_length_reg    <= 32'd0;
      field_header_position <= 2'd0;
      current_ident         <= 8'd0;
      current_length        <= 16'd0;
      value_position        <= 16'd0;
    end else if (step) begin
      phase                 <= phase_next;
      header_position       <= header_position_next;
      first_magic_byte      <= first_magic_byte_next;
      magic_bad             <= magic_bad_next;
      opcode_reg            <= opcode_reg_next;
      flags_reg             <= flags_reg_next;
      fields_total          <= fields_total_next;
      fields_left           <= fields_left_next;
      sequence_reg          <= sequence_reg_next;
      payload_length_reg    <= payload_length_reg_next;
      field_header_position <= field_header_position_next;
      current_ident         <= current_ident_next;
      current_length        <= current_length_next;
      value_position        <= value_position_next;
    end
  end

endmodule

[rtl/tlvp_out_reg.sv]
// ----------------------------------------------------------------------------
// tlvp_out_reg
// Result register with valid/ready handshake toward the consumer.
// ----------------------------------------------------------------------------
module tlvp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  tlvp_pkg::result_t result_in,
  output logic              space,
  output logic              result_valid,
  input  logic              result_ready,
  output tlvp_pkg::result_t result
);
  import tlvp_pkg::*;

  // The register can take a new result when empty or when it drains now.
  assign space = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_in;
    end
  end

endmodule

[rtl/tlv_frame_parser_core.sv]
// ----------------------------------------------------------------------------
// tlv_frame_parser_core
// Streaming type-length-value frame parser, one byte per request.
// ----------------------------------------------------------------------------
// The parser takes one frame byte per cycle and returns exactly one result per
// byte, in the cycle after the byte is taken. Each byte is handled by a single
// combinational update of the parser state that feeds the result register, so
// a new byte can follow in every cycle; item_ready only drops while the result
// register holds a result the consumer has not taken. The magic word must be
// loaded through the configuration channel while no frame is in flight.
module tlv_frame_parser_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  tlvp_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output tlvp_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);
  import tlvp_pkg::*;

  logic    [15:0] magic_word;
  logic           step;
  logic           space;
  result_t        step_result;

  assign cfg_ready  = 1'b1;
  assign item_ready = space;
  assign step       = item_valid && space;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word <= 16'd0;
    end else if (cfg_valid) begin
      magic_word <= cfg_data;
    end
  end

  tlvp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .item       (item),
    .magic_word (magic_word),
    .result     (step_result)
  );

  tlvp_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (step),
    .result_in    (step_result),
    .space        (space),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

[rtl/tlvp_checker.sv]
// ----------------------------------------------------------------------------
// tlvp_checker
// Port-level assertions for the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module tlvp_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input tlvp_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_ready,
  input tlvp_pkg::result_t result
);
  import tlvp_pkg::*;

  // An empty result register never holds back the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("input stalled with an empty result register");

  // Every accepted request shows up as a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> result_valid && result.frame_end == $past(item.frame_last))
    else $error("accepted byte did not produce its result");

  // A waiting result stays put until the consumer takes it.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed or dropped while waiting");

  // A status is only reported on the last byte of a frame.
  a_status_on_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.frame_end |-> result.status == ST_OK)
    else $error("status reported before frame end");

  // Value byte and index are zero unless a value byte is reported.
  a_value_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.event_res != EV_VALUE
      |-> result.value_byte == 8'd0 && result.value_index == 16'd0)
    else $error("value fields set without a value event");

endmodule

bind tlv_frame_parser_core tlvp_checker u_tlvp_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
